/* hdl/masked_lp_distance_top_assert.svh */
// Assertion macros for the masked Lp distance block.
// Used by masked_lp_distance_top only; no other dependencies.
`ifndef MASKED_LP_DISTANCE_TOP_ASSERT_SVH
`define MASKED_LP_DISTANCE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPD_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lpd_pkg.sv */
// Package for the masked Lp distance block: widths, register codes, shared types.
// No dependencies.
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int VAL_W       = 32;
  localparam int ACC_W       = 64;
  localparam int MD_W        = 31;
  localparam int RECIP_W     = 17;
  localparam int PANEL_W     = 16;
  localparam int POINT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int MAX_POINTS  = 65536;
  localparam int QUEUE_DEPTH = 2;
  localparam int SQRT_STEPS  = ACC_W / 2;
  localparam int PROD_W      = VAL_W + RECIP_W;
  localparam int FULL_W      = ACC_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(65536);
  localparam logic [VAL_W-1:0]   ONE_Q16     = VAL_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_MEAN_ABS,
    REG_MISSING_DISTANCE,
    REG_PANEL_MODE,
    REG_PANEL_PENALTY,
    REG_ONLY_PAST,
    REG_MEAN_RECIPROCAL
  } cfg_reg_t;

  typedef struct packed {
    logic                     use_mean_abs;
    logic [MD_W-1:0]          missing_distance;
    logic                     panel_mode;
    logic signed [VAL_W-1:0]  panel_penalty;
    logic                     only_past;
    logic [RECIP_W-1:0]       mean_reciprocal;
  } lpd_cfg_t;

  // One finished point handed from the front to the back.
  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic               skip;
    logic               mae;
    logic [MD_W-1:0]    pen;
    logic [POINT_W-1:0] index;
  } lpd_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADDP,
    BK_SQRT,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SUM,
    BK_PEN,
    BK_EMIT
  } bk_state_t;

endpackage

/* hdl/lpd_in_if.sv */
// Element pair channel: valid/ready plus the pair payload.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_in_if import lpd_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [VAL_W-1:0]       lib_value;
  logic signed [VAL_W-1:0]       pred_value;
  logic                          lib_missing;
  logic                          pred_missing;
  logic                          categorical;
  logic                          last_element;
  logic [PANEL_W-1:0]            lib_panel;
  logic [PANEL_W-1:0]            pred_panel;
  logic signed [VAL_W-1:0]       lib_target_time;
  logic signed [VAL_W-1:0]       pred_time;

  modport source (
    output valid, lib_value, pred_value, lib_missing, pred_missing, categorical,
           last_element, lib_panel, pred_panel, lib_target_time, pred_time,
    input  ready
  );
  modport sink (
    input  valid, lib_value, pred_value, lib_missing, pred_missing, categorical,
           last_element, lib_panel, pred_panel, lib_target_time, pred_time,
    output ready
  );
endinterface

/* hdl/lpd_out_if.sv */
// Result channel: valid/ready plus point index and distance.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_out_if import lpd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] point_index;
  logic [VAL_W-1:0]   distance;

  modport source (output valid, point_index, distance, input ready);
  modport sink (input valid, point_index, distance, output ready);
endinterface

/* hdl/lpd_cfg_if.sv */
// Configuration write channel: valid/ready, register index and write data.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_cfg_if import lpd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/masked_lp_distance_top.sv */
// Path: an element pair passes stage registers s1 and s2 to the accumulator; a finished point
// goes through the job queue, the back end (32-step square root in Euclidean mode, mean
// scaling in MAE) and the output register. Throughput: one element pair per cycle while the
// 2-entry job queue has room; the back end holds one point at a time, so runs of short points
// stall the input. Reset (rst, synchronous, active high) clears registers to their defaults, the
// accumulator, the point counter, the queue and the output register.
`timescale 1ns / 1ps

module masked_lp_distance_top import lpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lpd_in_if.sink    elem,
  lpd_cfg_if.sink   cfg,
  lpd_out_if.source result
);

`include "masked_lp_distance_top_assert.svh"

  lpd_cfg_t regs;
  lpd_job_t q_in;
  lpd_job_t q_out;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.use_mean_abs     <= 1'b0;
      regs.missing_distance <= '0;
      regs.panel_mode       <= 1'b0;
      regs.panel_penalty    <= '0;
      regs.only_past        <= 1'b0;
      regs.mean_reciprocal  <= RECIP_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_USE_MEAN_ABS:     regs.use_mean_abs     <= cfg.data[0];
        REG_MISSING_DISTANCE: regs.missing_distance <= cfg.data[MD_W-1:0];
        REG_PANEL_MODE:       regs.panel_mode       <= cfg.data[0];
        REG_PANEL_PENALTY:    regs.panel_penalty    <= cfg.data[VAL_W-1:0];
        REG_ONLY_PAST:        regs.only_past        <= cfg.data[0];
        REG_MEAN_RECIPROCAL:  regs.mean_reciprocal  <= cfg.data[RECIP_W-1:0];
        default:              regs <= regs;
      endcase
    end
  end

  lpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .elem     (elem),
    .job      (q_in),
    .job_push (q_push),
    .job_full (q_full)
  );

  lpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .job       (q_out),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .result    (result)
  );

  `LPD_ASSERT_IMPL(a_nonzero_out, clk, rst, result.valid, result.distance != '0, "zero distance")
  `LPD_ASSERT_IMPL(a_no_overflow, clk, rst, q_push, !q_full, "push into full queue")
  `LPD_ASSERT_IMPL(a_no_underflow, clk, rst, q_pop, !q_empty, "pop from empty queue")
  `LPD_ASSERT_NEXT(a_push_lands, clk, rst, q_push, !q_empty, "pushed job lost")

endmodule

/* hdl/lpd_front.sv */
// Front end: takes element pairs, forms per-element terms, accumulates one point.
// Pushes a finished point into the job queue. Depends on lpd_pkg, lpd_in_if.
`timescale 1ns / 1ps

module lpd_front import lpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lpd_cfg_t cfg,
  lpd_in_if.sink   elem,
  output lpd_job_t job,
  output logic     job_push,
  input  logic     job_full
);

  logic advance;

  // stage 1: element magnitude and point-level flags
  logic             s1_valid;
  logic [VAL_W-1:0] s1_mag;
  logic             s1_kill;
  logic             s1_last;
  logic             s1_skip_cfg;
  logic             s1_pen_add;

  // stage 2: term (magnitude or its square)
  logic             s2_valid;
  logic [ACC_W-1:0] s2_term;
  logic             s2_kill;
  logic             s2_last;
  logic             s2_skip_cfg;
  logic             s2_pen_add;

  logic [ACC_W-1:0]   acc;
  logic               invalid;
  logic [POINT_W-1:0] point_cnt;
  logic [POINT_W-1:0] point_cnt_next;
  logic [POINT_W:0]   cnt_inc;

  logic               missing;
  logic signed [VAL_W:0] diff;
  logic [VAL_W-1:0]   mag;
  logic               panel_diff;
  logic               skip_cfg;
  logic               pen_add;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]   acc_upd;
  logic               inv_upd;

  // the only stall: a last element waiting on a full queue
  assign advance    = !(s2_valid && s2_last && job_full);
  assign elem.ready = advance;

  always_comb begin
    missing    = elem.lib_missing | elem.pred_missing;
    diff       = {elem.lib_value[VAL_W-1], elem.lib_value} -
                 {elem.pred_value[VAL_W-1], elem.pred_value};
    if (missing) begin
      mag = {1'b0, cfg.missing_distance};
    end else if (elem.categorical) begin
      mag = (elem.lib_value != elem.pred_value) ? ONE_Q16 : '0;
    end else if (diff[VAL_W]) begin
      mag = VAL_W'(-diff);
    end else begin
      mag = diff[VAL_W-1:0];
    end
    panel_diff = elem.lib_panel != elem.pred_panel;
    skip_cfg   = (cfg.panel_mode && cfg.panel_penalty[VAL_W-1] && panel_diff) ||
                 (cfg.only_past && (elem.lib_target_time > elem.pred_time));
    pen_add    = cfg.panel_mode && !cfg.panel_penalty[VAL_W-1] &&
                 (cfg.panel_penalty != '0) && panel_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= elem.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mag      <= mag;
      s1_kill     <= missing && (cfg.missing_distance == '0);
      s1_last     <= elem.last_element;
      s1_skip_cfg <= skip_cfg;
      s1_pen_add  <= pen_add;
      s2_term     <= cfg.use_mean_abs ? {{(ACC_W-VAL_W){1'b0}}, s1_mag} : s1_mag * s1_mag;
      s2_kill     <= s1_kill;
      s2_last     <= s1_last;
      s2_skip_cfg <= s1_skip_cfg;
      s2_pen_add  <= s1_pen_add;
    end
  end

  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, s2_term};
    acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    inv_upd = invalid || s2_kill;
    acc_upd = inv_upd ? acc : acc_sat;
    cnt_inc = {1'b0, point_cnt} + 1'b1;
    if (32'(cnt_inc) >= MAX_POINTS) begin
      point_cnt_next = '0;
    end else begin
      point_cnt_next = cnt_inc[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      invalid   <= 1'b0;
      point_cnt <= '0;
    end else if (s2_valid && advance) begin
      if (s2_last) begin
        acc       <= '0;
        invalid   <= 1'b0;
        point_cnt <= point_cnt_next;
      end else begin
        acc     <= acc_upd;
        invalid <= inv_upd;
      end
    end
  end

  always_comb begin
    job.acc   = acc_upd;
    job.skip  = inv_upd || s2_skip_cfg;
    job.mae   = cfg.use_mean_abs;
    job.pen   = s2_pen_add ? cfg.panel_penalty[MD_W-1:0] : '0;
    job.index = point_cnt;
    job_push  = s2_valid && s2_last && !job_full;
  end

endmodule

/* hdl/lpd_queue.sv */
// Short job queue between front and back.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_queue import lpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  lpd_job_t push_data,
  output logic     full,
  input  logic     pop,
  output lpd_job_t pop_data,
  output logic     empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lpd_job_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/lpd_back.sv */
// Back end: finishes one point at a time (square root or mean scaling, penalty)
// and holds the result in an output register. Depends on lpd_pkg, lpd_out_if.
`timescale 1ns / 1ps

module lpd_back import lpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lpd_cfg_t cfg,
  input  lpd_job_t job,
  input  logic     job_empty,
  output logic     job_pop,
  lpd_out_if.source result
);

  bk_state_t state;
  bk_state_t state_next;

  logic [ACC_W-1:0]   work;
  logic [ACC_W-1:0]   root;
  logic [ACC_W-1:0]   bitm;
  logic [MD_W-1:0]    pen;
  logic [POINT_W-1:0] idx;
  logic [PROD_W-1:0]  prod_lo;
  logic [PROD_W-1:0]  prod_hi;
  logic [VAL_W-1:0]   point_dist;

  logic               out_valid;
  logic               load_out;

  logic [ACC_W:0]     padd;
  logic [ACC_W-1:0]   trial;
  logic               take;
  logic [ACC_W-1:0]   root_step;
  logic [FULL_W-1:0]  full;
  logic [VAL_W:0]     pen_sum;

  always_comb begin
    padd      = {1'b0, work} + {{(ACC_W-MD_W-15){1'b0}}, pen, 16'b0};
    trial     = root + bitm;
    take      = work >= trial;
    root_step = take ? (root >> 1) + bitm : root >> 1;
    full      = {prod_hi, 32'b0} + {{(FULL_W-PROD_W){1'b0}}, prod_lo};
    pen_sum   = {1'b0, point_dist} + {2'b0, pen};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!job_empty && !job.skip) begin
          state_next = job.mae ? BK_MUL_LO : BK_ADDP;
        end
      end
      BK_ADDP:   state_next = BK_SQRT;
      BK_SQRT: begin
        if (bitm == 64'd1) begin
          state_next = BK_EMIT;
        end
      end
      BK_MUL_LO: state_next = BK_MUL_HI;
      BK_MUL_HI: state_next = BK_SUM;
      BK_SUM:    state_next = BK_PEN;
      BK_PEN:    state_next = BK_EMIT;
      BK_EMIT: begin
        if (point_dist == '0 || load_out) begin
          state_next = BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: job_pop  = !job_empty;
      BK_EMIT: load_out = (point_dist != '0) && (!out_valid || result.ready);
      default: begin
        job_pop  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        work <= job.acc;
        pen  <= job.pen;
        idx  <= job.index;
      end
      BK_ADDP: begin
        work <= padd[ACC_W] ? '1 : padd[ACC_W-1:0];
        root <= '0;
        bitm <= 64'd1 << (ACC_W - 2);
      end
      BK_SQRT: begin
        if (take) begin
          work <= work - trial;
        end
        root       <= root_step;
        bitm       <= bitm >> 2;
        point_dist <= root_step[VAL_W-1:0];
      end
      BK_MUL_LO: prod_lo <= work[VAL_W-1:0] * cfg.mean_reciprocal;
      BK_MUL_HI: prod_hi <= work[ACC_W-1:VAL_W] * cfg.mean_reciprocal;
      BK_SUM:    point_dist <= (full[FULL_W-1:48] != '0) ? '1 : full[47:16];
      BK_PEN:    point_dist <= pen_sum[VAL_W] ? '1 : pen_sum[VAL_W-1:0];
      default: begin
        work <= work;
      end
    endcase
  end

  // output register decouples the result from the working state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.point_index <= idx;
      result.distance    <= point_dist;
    end
  end

  assign result.valid = out_valid;

endmodule
